// ===== src/ktd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the control store of the keyword transposition decoder.
package ktd_pkg;

	localparam int ALPHABET_SIZE = 26;
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_Z = 8'h5A;
	localparam logic [4:0] LAST_LETTER = 5'(ALPHABET_SIZE - 1);
	localparam logic [4:0] MAX_KEY = 5'(ALPHABET_SIZE);

	typedef logic [4:0] letter_t;

	// Step counter of the build sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_FILL,
		ST_COL,
		ST_CHAIN,
		ST_NEXT
	} step_t;

	// Branch condition of a control word
	typedef enum logic [2:0] {
		C_START,
		C_KZERO,
		C_CLAST,
		C_SEEN,
		C_FLT
	} cond_t;

	// Datapath operation of a control word
	typedef enum logic [2:0] {
		A_NONE,
		A_IDENT,
		A_CLR,
		A_FILL,
		A_HEAD,
		A_TAIL,
		A_CINC
	} act_t;

	typedef struct packed {
		cond_t cond;
		act_t  act_true;
		act_t  act_false;
		step_t next_true;
		step_t next_false;
	} ucode_t;

	// Datapath flags seen by the sequencer
	typedef struct packed {
		logic start;
		logic k_zero;
		logic c_last;
		logic seen_c;
		logic f_lt_nf;
	} status_t;

	// Control store: one word per step
	function automatic ucode_t ucode_rom(step_t step);
		ucode_t w;
		unique case (step)
			ST_IDLE:  w = '{C_START, A_NONE,  A_NONE, ST_CHK,   ST_IDLE};
			ST_CHK:   w = '{C_KZERO, A_IDENT, A_CLR,  ST_IDLE,  ST_FILL};
			ST_FILL:  w = '{C_CLAST, A_FILL,  A_FILL, ST_COL,   ST_FILL};
			ST_COL:   w = '{C_SEEN,  A_HEAD,  A_NONE, ST_CHAIN, ST_NEXT};
			ST_CHAIN: w = '{C_FLT,   A_TAIL,  A_NONE, ST_CHAIN, ST_NEXT};
			ST_NEXT:  w = '{C_CLAST, A_CINC,  A_CINC, ST_IDLE,  ST_COL};
			default:  w = '{C_START, A_NONE,  A_NONE, ST_IDLE,  ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== src/ktd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for cipher input and plain output.
interface ktd_cipher_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] char_in;
	logic       key_last;

	modport source (output valid, output func, output char_in, output key_last, input ready);
	modport sink (input valid, input func, input char_in, input key_last, output ready);
endinterface

interface ktd_plain_if;
	logic       valid;
	logic       ready;
	logic [7:0] plain_char;
	logic       was_letter;

	modport source (output valid, output plain_char, output was_letter, input ready);
	modport sink (input valid, input plain_char, input was_letter, output ready);
endinterface

// ===== src/ktd_seq.sv =====
`timescale 1ns / 1ps
// Microcoded sequencer: step counter, control store and branch select.
module ktd_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  ktd_pkg::status_t sts,
	output ktd_pkg::act_t    act,
	output logic             busy
);
	import ktd_pkg::*;

	step_t  step_q;
	step_t  step_d;
	ucode_t word;
	logic   taken;

	// Step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// Fetch, branch test, next step
	always_comb begin
		word = ucode_rom(step_q);
		unique case (word.cond)
			C_START: taken = sts.start;
			C_KZERO: taken = sts.k_zero;
			C_CLAST: taken = sts.c_last;
			C_SEEN:  taken = sts.seen_c;
			C_FLT:   taken = sts.f_lt_nf;
			default: taken = 1'b0;
		endcase
		act    = taken ? word.act_true : word.act_false;
		step_d = taken ? word.next_true : word.next_false;
		busy   = (step_q != ST_IDLE);
	end

endmodule

// ===== src/ktd_dp.sv =====
`timescale 1ns / 1ps
// Datapath: keyword capture, filler list, column walk and decode table.
module ktd_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             key_en,
	input  logic [7:0]       key_char,
	input  logic             key_end,
	input  ktd_pkg::act_t    act,
	input  ktd_pkg::letter_t look_idx,
	output ktd_pkg::letter_t look_val,
	output ktd_pkg::status_t sts
);
	import ktd_pkg::*;

	logic [ALPHABET_SIZE-1:0] seen_q;
	logic [4:0]               count_q;
	logic                     collecting_q;
	letter_t                  pos_q [ALPHABET_SIZE];
	letter_t                  fill_q [ALPHABET_SIZE];
	letter_t                  table_q [ALPHABET_SIZE];
	letter_t                  c_q;
	logic [4:0]               nf_q;
	logic [4:0]               n_q;
	logic [5:0]               f_q;

	logic [ALPHABET_SIZE-1:0] seen_base;
	logic [4:0]               count_base;
	logic [7:0]               key_off;
	letter_t                  kidx;
	logic                     is_letter;
	logic                     keep;
	letter_t                  c_inc;

	// Keyword letter filter; a fresh keyword starts from an empty set
	always_comb begin
		seen_base  = collecting_q ? seen_q : '0;
		count_base = collecting_q ? count_q : '0;
		key_off    = key_char - CHAR_A;
		kidx       = key_off[4:0];
		is_letter  = (key_char >= CHAR_A) && (key_char <= CHAR_Z);
		keep       = is_letter && !seen_base[kidx] && (count_base < MAX_KEY);
		c_inc      = (c_q == LAST_LETTER) ? '0 : c_q + 5'd1;
	end

	// Keyword state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= '0;
			count_q      <= '0;
			collecting_q <= 1'b0;
		end else if (key_en) begin
			seen_q       <= seen_base | (keep ? (ALPHABET_SIZE'(1) << kidx) : '0);
			count_q      <= count_base + {4'd0, keep};
			collecting_q <= !key_end;
		end
	end

	// Column position of each kept letter
	always_ff @(posedge clk) begin
		if (key_en && keep) begin
			pos_q[kidx] <= count_base;
		end
	end

	// Filler list, built in alphabetical order
	always_ff @(posedge clk) begin
		if (act == A_FILL && !seen_q[c_q]) begin
			fill_q[nf_q] <= c_q;
		end
	end

	// Walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q  <= '0;
			nf_q <= '0;
			n_q  <= '0;
			f_q  <= '0;
		end else begin
			unique case (act)
				A_CLR: begin
					c_q  <= '0;
					nf_q <= '0;
					n_q  <= '0;
				end
				A_FILL: begin
					c_q  <= c_inc;
					nf_q <= nf_q + {4'd0, !seen_q[c_q]};
				end
				A_HEAD: begin
					n_q <= n_q + 5'd1;
					f_q <= {1'b0, pos_q[c_q]};
				end
				A_TAIL: begin
					n_q <= n_q + 5'd1;
					f_q <= f_q + {1'b0, count_q};
				end
				A_CINC: begin
					c_q <= c_inc;
				end
				default: begin
				end
			endcase
		end
	end

	// Decode table, identity out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALPHABET_SIZE; i++) begin
				table_q[i] <= letter_t'(i);
			end
		end else begin
			unique case (act)
				A_IDENT: begin
					for (int i = 0; i < ALPHABET_SIZE; i++) begin
						table_q[i] <= letter_t'(i);
					end
				end
				A_HEAD: table_q[c_q] <= n_q;
				A_TAIL: table_q[fill_q[f_q[4:0]]] <= n_q;
				default: begin
				end
			endcase
		end
	end

	// Lookup and flags
	always_comb begin
		look_val    = table_q[look_idx];
		sts.start   = key_en && key_end;
		sts.k_zero  = (count_q == '0);
		sts.c_last  = (c_q == LAST_LETTER);
		sts.seen_c  = seen_q[c_q];
		sts.f_lt_nf = (f_q < {1'b0, nf_q});
	end

endmodule

// ===== src/keyword_transposition_decoder.sv =====
`timescale 1ns / 1ps
// Keyword transposition decoder top level: handshake, output register, sequencer and datapath.
// A text request's result is registered in the cycle after acceptance; a keyword request updates the keyword state.
// The last keyword letter starts the table build, run by the microcoded sequencer: an empty keyword
// restores the identity table, otherwise it clears, sweeps the filler list, then walks the columns.
// No request is taken during the build. Reset clears control state; the table reads identity.
module keyword_transposition_decoder (
	input  logic clk,
	input  logic arst_n,
	ktd_cipher_if.sink  cipher,
	ktd_plain_if.source plain
);
	import ktd_pkg::*;

	act_t       act;
	status_t    sts;
	logic       busy;
	logic       accept;
	logic       key_en;
	logic       text_en;
	logic [7:0] text_off;
	letter_t    look_val;
	logic       text_letter;

	logic       out_valid_q;
	logic [7:0] plain_char_q;
	logic       was_letter_q;

	// Handshake: hold off during the build or while the result slot stays full
	always_comb begin
		cipher.ready = !busy && (!out_valid_q || plain.ready);
		accept       = cipher.valid && cipher.ready;
		key_en       = accept && !cipher.func;
		text_en      = accept && cipher.func;
		text_off     = cipher.char_in - CHAR_A;
		text_letter  = (cipher.char_in >= CHAR_A) && (cipher.char_in <= CHAR_Z);
	end

	ktd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.act    (act),
		.busy   (busy)
	);

	ktd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_en   (key_en),
		.key_char (cipher.char_in),
		.key_end  (cipher.key_last),
		.act      (act),
		.look_idx (text_off[4:0]),
		.look_val (look_val),
		.sts      (sts)
	);

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (text_en) begin
			out_valid_q <= 1'b1;
		end else if (plain.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (text_en) begin
			plain_char_q <= text_letter ? (CHAR_A + {3'd0, look_val}) : cipher.char_in;
			was_letter_q <= text_letter;
		end
	end

	assign plain.valid      = out_valid_q;
	assign plain.plain_char = plain_char_q;
	assign plain.was_letter = was_letter_q;

endmodule
